### design/irs_pkg.sv
// Package for the integer to radix string unit: beat types, widths,
// character codes and the digit-to-ASCII mapping. No dependencies.
package irs_pkg;

	localparam int VALUE_WIDTH = 32;
	localparam int MAX_BASE    = 32;
	localparam int BASE_W      = 8;
	localparam int CHAR_W      = 7;
	localparam int DIVISOR_W   = $clog2(MAX_BASE + 1);
	localparam int DIGIT_W     = $clog2(MAX_BASE);
	localparam int CNT_W       = $clog2(VALUE_WIDTH + 1);
	localparam int IDX_W       = $clog2(VALUE_WIDTH);
	localparam int STEP_W      = $clog2(VALUE_WIDTH);

	localparam logic [CHAR_W-1:0] CHAR_MINUS = CHAR_W'(8'h2d);
	localparam logic [CHAR_W-1:0] CHAR_ZERO  = CHAR_W'(8'h30);
	localparam logic [CHAR_W-1:0] CHAR_A     = CHAR_W'(8'h61);
	localparam logic [CHAR_W-1:0] CHAR_NONE  = '0;
	localparam logic [BASE_W-1:0] BASE_TEN   = BASE_W'(10);
	localparam logic [BASE_W-1:0] BASE_MIN   = BASE_W'(2);
	localparam logic [BASE_W-1:0] BASE_MAX   = BASE_W'(MAX_BASE);

	typedef struct packed {
		logic [VALUE_WIDTH-1:0] value;
		logic [BASE_W-1:0]      base;
	} in_beat_t;

	typedef struct packed {
		logic [CHAR_W-1:0] character;
		logic              last;
		logic              error;
	} out_beat_t;

	typedef struct packed {
		logic                   start;
		logic [VALUE_WIDTH-1:0] dividend;
		logic [DIVISOR_W-1:0]   divisor;
	} div_req_t;

	typedef struct packed {
		logic                   done;
		logic [VALUE_WIDTH-1:0] quot;
		logic [DIGIT_W-1:0]     rem;
	} div_res_t;

	function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] dx;
		dx = CHAR_W'(d);
		if (dx < CHAR_W'(10))
			return CHAR_ZERO + dx;
		else
			return CHAR_A + dx - CHAR_W'(10);
	endfunction

endpackage

### design/integer_to_radix_string_unit.sv
// Top level of the integer to radix string unit: sequencer, digit stack,
// output register. Depends on irs_pkg and irs_div.
//
// Usage:
//   src channel: one beat carries a 32-bit value and an 8-bit base. The unit
//   stalls src while a conversion is in progress and accepts one item at a
//   time. dst channel: one beat per ASCII character, most significant digit
//   first, '-' leading for a negative value in base ten; last marks the
//   final character. An unusable base (above 32, or 0/1 with a nonzero
//   value) gives a single beat with error and last set and character 0.
//   A zero value with a base of 32 or less gives a single '0'.
// Timing:
//   Each digit costs one run of the bit-serial divider (load, one shift per
//   dividend bit, handoff), so an item takes longer the more digits it has.
//   The unit returns to idle and can take the next item once the last beat
//   of the current one is loaded into the output register; that load waits
//   on dst_stall. Special cases (zero, error) skip the divider.
// Reset:
//   arst_n clears the sequencer and output valid; the digit stack needs no clearing.
// Backpressure:
//   While dst_stall is high the current beat holds and the sequencer waits to emit;
//   no character is lost or repeated.
module integer_to_radix_string_unit import irs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      src_valid,
	output logic      src_stall,
	input  in_beat_t  src_data,
	output logic      dst_valid,
	input  logic      dst_stall,
	output out_beat_t dst_data
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	state_t                 state_q;
	logic                   start_q;
	logic [VALUE_WIDTH-1:0] quot_q;
	logic [DIVISOR_W-1:0]   divisor_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   sign_q;
	logic                   spec_q;
	logic [CHAR_W-1:0]      spec_char_q;
	logic                   spec_err_q;
	logic [DIGIT_W-1:0]     stack_q [VALUE_WIDTH];
	logic                   dst_valid_q;
	out_beat_t              dst_data_q;

	div_req_t               div_req;
	div_res_t               div_res;

	logic                   accept;
	logic                   slot_free;
	logic                   neg;
	logic [VALUE_WIDTH-1:0] mag;
	logic                   base_high;
	logic                   base_low;
	logic                   val_zero;
	logic [CNT_W-1:0]       cnt_dec;

	assign accept    = src_valid && !src_stall;
	assign src_stall = (state_q != ST_IDLE);
	assign slot_free = !dst_valid_q || !dst_stall;

	// decode the incoming beat
	assign base_high = (src_data.base > BASE_MAX);
	assign base_low  = (src_data.base < BASE_MIN);
	assign val_zero  = (src_data.value == '0);
	assign neg       = (src_data.base == BASE_TEN) && src_data.value[VALUE_WIDTH-1];
	assign mag       = neg ? (~src_data.value + 1'b1) : src_data.value;
	assign cnt_dec   = cnt_q - 1'b1;

	assign div_req.start    = start_q;
	assign div_req.dividend = quot_q;
	assign div_req.divisor  = divisor_q;

	irs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.res    (div_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			start_q     <= 1'b0;
			cnt_q       <= '0;
			sign_q      <= 1'b0;
			spec_q      <= 1'b0;
			dst_valid_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			// drop the beat once the receiver takes it
			if (dst_valid_q && !dst_stall)
				dst_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cnt_q <= '0;
						if (base_high || val_zero || base_low) begin
							// single-beat result: error or lone '0'
							spec_q  <= 1'b1;
							sign_q  <= 1'b0;
							state_q <= ST_EMIT;
						end else begin
							spec_q  <= 1'b0;
							sign_q  <= neg;
							start_q <= 1'b1;
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					if (div_res.done) begin
						cnt_q <= cnt_q + 1'b1;
						if (div_res.quot == '0)
							state_q <= ST_EMIT;
						else
							start_q <= 1'b1;
					end
				end
				ST_EMIT: begin
					if (slot_free) begin
						dst_valid_q <= 1'b1;
						if (spec_q) begin
							spec_q  <= 1'b0;
							state_q <= ST_IDLE;
						end else if (sign_q) begin
							sign_q <= 1'b0;
						end else begin
							cnt_q <= cnt_dec;
							if (cnt_q == CNT_W'(1))
								state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload: operand, digit stack and output beat
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept) begin
			quot_q      <= mag;
			divisor_q   <= src_data.base[DIVISOR_W-1:0];
			spec_err_q  <= base_high || (!val_zero && base_low);
			spec_char_q <= (base_high || !val_zero) ? CHAR_NONE : CHAR_ZERO;
		end
		if (state_q == ST_DIV && div_res.done) begin
			stack_q[cnt_q[IDX_W-1:0]] <= div_res.rem;
			quot_q                    <= div_res.quot;
		end
		if (state_q == ST_EMIT && slot_free) begin
			if (spec_q) begin
				dst_data_q.character <= spec_char_q;
				dst_data_q.last      <= 1'b1;
				dst_data_q.error     <= spec_err_q;
			end else if (sign_q) begin
				dst_data_q.character <= CHAR_MINUS;
				dst_data_q.last      <= 1'b0;
				dst_data_q.error     <= 1'b0;
			end else begin
				dst_data_q.character <= digit_char(stack_q[cnt_dec[IDX_W-1:0]]);
				dst_data_q.last      <= (cnt_q == CNT_W'(1));
				dst_data_q.error     <= 1'b0;
			end
		end
	end

	assign dst_valid = dst_valid_q;
	assign dst_data  = dst_data_q;

endmodule

### design/irs_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on irs_pkg for widths and the request/result structs.
module irs_div import irs_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_res_t res
);

	logic                   busy_q;
	logic                   done_q;
	logic [STEP_W-1:0]      step_q;
	logic [VALUE_WIDTH-1:0] quot_q;
	logic [DIGIT_W-1:0]     rem_q;
	logic [DIVISOR_W-1:0]   divisor_q;
	logic [DIGIT_W:0]       trial;
	logic                   fits;
	logic [DIGIT_W:0]       diff;

	// trial remainder: shift in the next dividend bit, then compare
	assign trial = {rem_q, quot_q[VALUE_WIDTH-1]};
	assign fits  = ((DIGIT_W + 1)'(divisor_q) <= trial);
	assign diff  = trial - (DIGIT_W + 1)'(divisor_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(VALUE_WIDTH - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quot_q    <= req.dividend;
			rem_q     <= '0;
			divisor_q <= req.divisor;
		end else if (busy_q) begin
			quot_q <= {quot_q[VALUE_WIDTH-2:0], fits};
			rem_q  <= fits ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
		end
	end

	assign res.done = done_q;
	assign res.quot = quot_q;
	assign res.rem  = rem_q;

endmodule
